### src/smss_pkg.sv
// Shared types and constants for the sorted-matrix staircase search unit.
// No dependencies; every other file in src/ imports this package.
package smss_pkg;

  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;
  localparam int DATA_W   = 32;

  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int CNT_W    = $clog2(MAX_ROWS + 1) > $clog2(MAX_COLS + 1) ?
                            $clog2(MAX_ROWS + 1) : $clog2(MAX_COLS + 1);

  // Field widths fixed by the item format
  localparam int IDX_W    = 3;
  localparam int VAL_W    = 32;
  localparam int IN_BITS  = 2 * IDX_W + 2 * VAL_W;
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 1 + 2 * IDX_W;
  localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;
  localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(8);
  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(8);

  // Action codes carried in tuser
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic                     is_search;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

endpackage

### src/smss_front.sv
// Front end: unpacks an input beat and classifies it as a load or a search.
// Depends on smss_pkg; feeds smss_fifo.
module smss_front (
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [smss_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic [0:0]                       s_axis_tuser_i,
  input  logic                             full_i,
  output logic                             push_o,
  output smss_pkg::cmd_t                   cmd_o
);
  import smss_pkg::*;

  logic [IDX_W-1:0] row, col;
  logic [VAL_W-1:0] elem, key;

  assign row  = s_axis_tdata_i[IDX_W-1:0];
  assign col  = s_axis_tdata_i[2*IDX_W-1:IDX_W];
  assign elem = s_axis_tdata_i[2*IDX_W+VAL_W-1:2*IDX_W];
  assign key  = s_axis_tdata_i[2*IDX_W+2*VAL_W-1:2*IDX_W+VAL_W];

  assign s_axis_tready_o = !full_i;
  assign push_o          = s_axis_tvalid_i && !full_i;

  always_comb begin
    cmd_o.is_search = (s_axis_tuser_i[0] == ACT_SEARCH);
    cmd_o.row       = row;
    cmd_o.col       = col;
    // One value slot: the key for a search, the element for a load
    cmd_o.value     = cmd_o.is_search ? DATA_W'(key) : DATA_W'(elem);
  end

endmodule

### src/smss_fifo.sv
// Short command queue between the front end and the search engine.
// Depends on smss_pkg for the command type and depth.
module smss_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  smss_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output smss_pkg::cmd_t pop_data_o
);
  import smss_pkg::*;

  cmd_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]    cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o     = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### src/smss_engine.sv
// Back end: matrix memory, size registers and the staircase walk sequencer.
// Depends on smss_pkg; pops commands from smss_fifo, drives the result register.
module smss_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [smss_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [smss_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           cmd_empty_i,
  input  smss_pkg::cmd_t                 cmd_i,
  output logic                           cmd_pop_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [smss_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);
  import smss_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]               st_q, st_d;
  logic [CFG_W-1:0]         rows_q, cols_q;
  logic [CNT_W-1:0]         rows_eff, cols_eff;
  logic [CNT_W-1:0]         x_q, x_d, y_q, y_d, x_nx, y_nx;
  logic signed [DATA_W-1:0] key_q, key_d, rd_data_q;
  logic [ADDR_W-1:0]        rd_addr, wr_addr;
  logic                     mem_we;
  logic signed [DATA_W-1:0] mem_q [DEPTH];

  logic                     hit_q, hit_d;
  logic [IDX_W-1:0]         hrow_q, hrow_d, hcol_q, hcol_d;
  logic                     out_vld_q, out_vld_d, out_load;
  logic [OUT_BITS-1:0]      out_q;

  assign rows_eff = (rows_q > CFG_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : CNT_W'(rows_q);
  assign cols_eff = (cols_q > CFG_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : CNT_W'(cols_q);
  assign x_nx     = x_q + 1'b1;
  assign y_nx     = y_q - 1'b1;
  assign wr_addr  = {cmd_i.row[ROW_W-1:0], cmd_i.col[COL_W-1:0]};

  always_comb begin
    st_d      = st_q;
    x_d       = x_q;
    y_d       = y_q;
    key_d     = key_q;
    hit_d     = hit_q;
    hrow_d    = hrow_q;
    hcol_d    = hcol_q;
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    rd_addr   = {x_q[ROW_W-1:0], y_nx[COL_W-1:0]};
    unique case (st_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (!cmd_i.is_search) begin
            mem_we = ({1'b0, cmd_i.row} < (IDX_W+1)'(MAX_ROWS)) &&
                     ({1'b0, cmd_i.col} < (IDX_W+1)'(MAX_COLS));
          end else begin
            key_d  = cmd_i.value;
            hit_d  = 1'b0;
            hrow_d = '0;
            hcol_d = '0;
            x_d    = '0;
            y_d    = cols_eff;
            rd_addr = {ROW_W'(0), COL_W'(cols_eff - 1'b1)};
            // Empty region: report not found without walking
            st_d   = (rows_eff == '0 || cols_eff == '0) ? ST_DONE : ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (key_q > rd_data_q) begin
          x_d     = x_nx;
          rd_addr = {x_nx[ROW_W-1:0], y_nx[COL_W-1:0]};
          if (x_nx == rows_eff) st_d = ST_DONE;
        end else if (key_q < rd_data_q) begin
          y_d     = y_nx;
          rd_addr = {x_q[ROW_W-1:0], COL_W'(y_nx - 1'b1)};
          if (y_nx == '0) st_d = ST_DONE;
        end else begin
          hit_d  = 1'b1;
          hrow_d = IDX_W'(x_q);
          hcol_d = IDX_W'(y_nx);
          st_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      rows_q    <= ROWS_RESET;
      cols_q    <= COLS_RESET;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i && cfg_idx_i == REG_ROWS) rows_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == REG_COLS) cols_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    key_q  <= key_d;
    hit_q  <= hit_d;
    hrow_q <= hrow_d;
    hcol_q <= hcol_d;
    if (out_load) begin
      out_q <= {hcol_q, hrow_q, hit_q};
    end
  end

  // Matrix store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= cmd_i.value;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = M_TDATA_W'(out_q);

endmodule

### src/sorted_matrix_staircase_search_unit.sv
// A search is queued, popped in ST_IDLE, walked in ST_WALK over at most
// rows_in_use + cols_in_use - 1 cells (15 at 8 by 8) and its result loaded in
// ST_DONE; a load is popped and written in ST_IDLE. The engine holds one item at
// a time, a search until its result loads, which a result stall can delay; a
// 2-entry queue takes beats meanwhile. Reset clears control state and sets both
// size registers to 8; matrix contents are undefined until loaded.
module sorted_matrix_staircase_search_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [smss_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [smss_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // row_index[2:0], col_index[5:3], element_value[37:6], search_key[69:38]
  input  logic [smss_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // action[0]
  input  logic [0:0]                     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // found[0], found_row[3:1], found_col[6:4]
  output logic [smss_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);
  import smss_pkg::*;

  cmd_t front_cmd, queue_cmd;
  logic push, full, pop, empty;

  smss_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .full_i          (full),
    .push_o          (push),
    .cmd_o           (front_cmd)
  );

  smss_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (queue_cmd)
  );

  smss_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_empty_i     (empty),
    .cmd_i           (queue_cmd),
    .cmd_pop_o       (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

### src/smss_checker.sv
// Port-level checks for the staircase search unit, bound to the top level.
// Depends on smss_pkg for port widths.
module smss_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [smss_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);
  import smss_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // A miss reports row and column zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[OUT_BITS-1:1] == '0)
    else $error("miss with nonzero row or column");

  // No result beat while in reset
  a_rst_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

endmodule

bind sorted_matrix_staircase_search_unit smss_checker u_smss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

### dv/staircase_search_checker.sv
// Checker for the staircase search unit: watches the config port and both stream
// channels, keeps its own copy of the matrix and size registers, and scores each
// result beat against the walk it predicts. Depends on smss_pkg.
module staircase_search_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [smss_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [smss_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [smss_pkg::S_TDATA_W-1:0] s_tdata_i,
  input  logic [0:0]                     s_tuser_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [smss_pkg::M_TDATA_W-1:0] m_tdata_i,
  output int                             mismatch_count_o,
  output int                             pending_hits_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import smss_pkg::*;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } hit_t;

  logic signed [DATA_W-1:0] cells [DEPTH];
  logic [CFG_W-1:0]         rows_cfg;
  logic [CFG_W-1:0]         cols_cfg;
  hit_t                     expected_hits [$];
  hit_t                     want;
  hit_t                     got;
  logic [IDX_W-1:0]         ld_row;
  logic [IDX_W-1:0]         ld_col;

  // Walk from the top-right cell of the active region: down on greater, left on smaller.
  function automatic hit_t walk_staircase(logic signed [DATA_W-1:0] key);
    int   nrows;
    int   ncols;
    int   r;
    int   c;
    logic done;
    logic signed [DATA_W-1:0] entry_val;
    hit_t res;
    nrows = (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
    ncols = (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
    res   = '0;
    r     = 0;
    c     = ncols;
    done  = 1'b0;
    while (!done && r < nrows && c > 0) begin
      entry_val = cells[r * MAX_COLS + c - 1];
      if (key > entry_val) begin
        r++;
      end else if (key < entry_val) begin
        c--;
      end else begin
        res.found = 1'b1;
        res.row   = IDX_W'(r);
        res.col   = IDX_W'(c - 1);
        done      = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg = ROWS_RESET;
      cols_cfg = COLS_RESET;
      expected_hits.delete();
      pending_hits_o   = 0;
      mismatch_count_o = 0;
    end else begin
      // result beat: found[0], found_row[3:1], found_col[6:4]
      if (m_tvalid_i && m_tready_i) begin
        got = hit_t'({m_tdata_i[0], m_tdata_i[3:1], m_tdata_i[6:4]});
        if (expected_hits.size() == 0) begin
          $error("result beat with no search outstanding: tdata %h", m_tdata_i);
          mismatch_count_o++;
        end else begin
          want = expected_hits.pop_front();
          pending_hits_o = expected_hits.size();
          if (got.found !== want.found) begin
            $error("found mismatch: expected %0d, actual %0d", want.found, got.found);
            mismatch_count_o++;
          end
          if (got.row !== want.row) begin
            $error("found_row mismatch: expected %0d, actual %0d", want.row, got.row);
            mismatch_count_o++;
          end
          if (got.col !== want.col) begin
            $error("found_col mismatch: expected %0d, actual %0d", want.col, got.col);
            mismatch_count_o++;
          end
        end
      end

      if (cfg_we_i) begin
        if (cfg_idx_i == REG_ROWS) begin
          rows_cfg = cfg_data_i;
        end else if (cfg_idx_i == REG_COLS) begin
          cols_cfg = cfg_data_i;
        end
      end

      // input beat: row[2:0], col[5:3], value[37:6], key[69:38]
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i[0] == ACT_LOAD) begin
          ld_row = s_tdata_i[2:0];
          ld_col = s_tdata_i[5:3];
          cells[ld_row * MAX_COLS + ld_col] = s_tdata_i[37:6];
        end else begin
          expected_hits.push_back(walk_staircase(s_tdata_i[69:38]));
          pending_hits_o = expected_hits.size();
        end
      end
    end
  end

endmodule

### dv/sorted_matrix_staircase_search_unit_test.sv
// Top of the staircase search testbench: clock, reset, size register writes,
// load and search traffic with random idling, and the verdict.
// Depends on smss_pkg, the unit under test and staircase_search_checker.
module sorted_matrix_staircase_search_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import smss_pkg::*;

  localparam int TOTAL_ITEMS   = 1500;
  localparam int QUIET_TAIL    = 200;
  localparam int SETTLE_CYCLES = 30;
  localparam int INT_MIN       = 32'sh8000_0000;
  localparam int INT_MAX       = 32'sh7fff_ffff;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  logic                 s_valid;
  logic                 s_ready;
  logic [S_TDATA_W-1:0] s_data;
  logic [0:0]           s_user;
  logic                 m_valid;
  logic                 m_ready;
  logic [M_TDATA_W-1:0] m_data;
  int                   mismatch_count;
  int                   pending_hits;

  int grid [MAX_ROWS][MAX_COLS];
  int items_sent;
  int rows_cur;
  int cols_cur;
  bit send_idle;
  bit recv_idle;

  sorted_matrix_staircase_search_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  staircase_search_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .s_tvalid_i       (s_valid),
    .s_tready_i       (s_ready),
    .s_tdata_i        (s_data),
    .s_tuser_i        (s_user),
    .m_tvalid_i       (m_valid),
    .m_tready_i       (m_ready),
    .m_tdata_i        (m_data),
    .mismatch_count_o (mismatch_count),
    .pending_hits_o   (pending_hits)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: stall tready in short bursts while idling is enabled.
  initial begin
    int n;
    m_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (recv_idle && $urandom_range(0, 4) == 0) begin
        m_ready = 1'b0;
        n = $urandom_range(1, 3);
        repeat (n - 1) @(negedge clk);
      end else begin
        m_ready = 1'b1;
      end
    end
  end

  // Returns right after the accepting edge with tvalid still high.
  task automatic send_beat(input logic act, input int r, input int c, input int v,
                           input int k);
    int gap;
    if (send_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      s_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_valid = 1'b1;
    s_user  = act;
    s_data  = {2'b00, k, v, c[2:0], r[2:0]};
    do @(posedge clk); while (!s_ready);
    items_sent++;
  endtask

  task automatic load_cell(input int r, input int c, input int v);
    grid[r][c] = v;
    send_beat(ACT_LOAD, r, c, v, int'($urandom));
  endtask

  task automatic search_for(input int k);
    send_beat(ACT_SEARCH, $urandom_range(0, 7), $urandom_range(0, 7), int'($urandom), k);
  endtask

  // Hold input until every result is back, then let trailing loads retire.
  task automatic drain();
    @(negedge clk);
    s_valid = 1'b0;
    while (pending_hits != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val[CFG_W-1:0];
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  task automatic set_size(input int r, input int c);
    drain();
    write_reg(REG_ROWS, r);
    write_reg(REG_COLS, c);
    rows_cur = r;
    cols_cur = c;
  endtask

  // Load the active region with rows and columns ascending.
  task automatic fill_region();
    int     nr;
    int     nc;
    int     step;
    longint base;
    longint v;
    nr = (rows_cur > MAX_ROWS) ? MAX_ROWS : rows_cur;
    nc = (cols_cur > MAX_COLS) ? MAX_COLS : cols_cur;
    case ($urandom_range(0, 2))
      0: begin
        base = longint'($urandom_range(0, 200)) - 100;
        step = 3;
      end
      1: begin
        base = longint'(INT_MIN) + $urandom_range(0, 15);
        step = 1 << 29;
      end
      default: begin
        base = longint'(int'($urandom)) / 4;
        step = $urandom_range(1, 1 << 20);
      end
    endcase
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        if (r == 0 && c == 0) begin
          v = base;
        end else if (r == 0) begin
          v = longint'(grid[r][c-1]) + $urandom_range(0, step);
        end else if (c == 0) begin
          v = longint'(grid[r-1][c]) + $urandom_range(0, step);
        end else begin
          v = (grid[r-1][c] > grid[r][c-1]) ? longint'(grid[r-1][c]) : longint'(grid[r][c-1]);
          v = v + $urandom_range(0, step);
        end
        if (v > longint'(INT_MAX)) v = INT_MAX;
        load_cell(r, c, int'(v));
      end
    end
  endtask

  function automatic int pick_key();
    int nr;
    int nc;
    int sel;
    int k;
    nr  = (rows_cur > MAX_ROWS) ? MAX_ROWS : rows_cur;
    nc  = (cols_cur > MAX_COLS) ? MAX_COLS : cols_cur;
    sel = $urandom_range(0, 9);
    if (nr == 0 || nc == 0 || sel < 3) return int'($urandom);
    k = grid[$urandom_range(0, nr - 1)][$urandom_range(0, nc - 1)];
    case (sel)
      6:       return k + 1;
      7:       return k - 1;
      8:       return INT_MIN;
      9:       return INT_MAX;
      default: return k;
    endcase
  endfunction

  initial begin
    int sel;
    int n;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = REG_ROWS;
    cfg_data   = '0;
    s_valid    = 1'b0;
    s_user     = ACT_LOAD;
    s_data     = '0;
    send_idle  = 1'b1;
    recv_idle  = 1'b1;
    items_sent = 0;
    rows_cur   = 8;
    cols_cur   = 8;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Column 0 spans the full value range; a 2x2 corner sits on top of it.
    load_cell(0, 0, INT_MIN);
    load_cell(1, 0, -1000);
    load_cell(2, 0, -1);
    load_cell(3, 0, 0);
    load_cell(4, 0, 1);
    load_cell(5, 0, 1000);
    load_cell(6, 0, 1 << 30);
    load_cell(7, 0, INT_MAX);
    load_cell(0, 1, -500);
    load_cell(1, 1, 5000);

    // oversized row count saturates; one column walks straight down
    set_size(15, 1);
    search_for(INT_MIN);
    search_for(INT_MAX);
    search_for(0);
    search_for(500);
    search_for(-2);

    set_size(2, 2);
    search_for(-1000);
    search_for(5000);
    search_for(0);
    search_for(INT_MIN);

    // empty region: never found
    set_size(0, 2);
    search_for(5000);
    set_size(2, 0);
    search_for(-500);

    set_size(8, 8);
    fill_region();

    while (items_sent < TOTAL_ITEMS) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       set_size(0, $urandom_range(0, 15));
        1:       set_size($urandom_range(1, 8), 0);
        2:       set_size($urandom_range(9, 15), $urandom_range(9, 15));
        3:       set_size(1, 1);
        4:       set_size(8, 8);
        default: set_size($urandom_range(1, 8), $urandom_range(1, 8));
      endcase
      if (items_sent > TOTAL_ITEMS - QUIET_TAIL) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end else begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      fill_region();
      n = $urandom_range(15, 40);
      repeat (n) begin
        // stray loads break the ordering now and then
        if ($urandom_range(0, 9) == 0) begin
          load_cell($urandom_range(0, 7), $urandom_range(0, 7), int'($urandom));
        end else begin
          search_for(pick_key());
        end
      end
    end

    @(negedge clk);
    s_valid = 1'b0;
    while (pending_hits != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_hits == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sorted_matrix_staircase_search_unit.f
src/smss_pkg.sv
src/smss_front.sv
src/smss_fifo.sv
src/smss_engine.sv
src/sorted_matrix_staircase_search_unit.sv
src/smss_checker.sv
dv/staircase_search_checker.sv
dv/sorted_matrix_staircase_search_unit_test.sv
